// ===== design/image_convolution_3x3_top_macros.svh =====
// Assertion macros used by the checker of the 3x3 convolution block.
`ifndef IMAGE_CONVOLUTION_3X3_TOP_MACROS_SVH
`define IMAGE_CONVOLUTION_3X3_TOP_MACROS_SVH

// Checked on every edge, reset included.
`define IC3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define IC3_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== design/ic3_pkg.sv =====
package ic3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int WID_W      = 11;
  localparam int HGT_W      = 13;
  localparam int COEF_BITS  = 16;
  localparam int COEF_SLOT  = 16;
  localparam int TAPS       = 9;
  localparam int TAP_W      = 4;
  localparam int CHAN_MAX   = 255;
  localparam int PIX_W      = 32;
  localparam int ACC_W      = 29;
  localparam int KS_W       = 20;
  localparam int DIV_W      = 29;
  localparam int QBITS      = 8;
  localparam int SLOT_W     = 2;
  localparam int RING_AW    = SLOT_W + COL_W;
  localparam int RING_DEPTH = 3 * MAX_WIDTH;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DW     = 48;
  localparam int KROW_W     = 3 * COEF_SLOT;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_KTOP   = 3'd2,
    CFG_KMID   = 3'd3,
    CFG_KBOT   = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic             start;
    logic             fetch;
    logic [TAP_W-1:0] tap;
    logic             div_init;
    logic             div_step;
    logic             finish;
    logic             update;
  } ic3_cmd_t;

  typedef struct packed {
    logic need_emit;
    logic need_write;
    logic out_busy;
  } ic3_sts_t;

endpackage

// ===== design/ic3_ctrl.sv =====
module ic3_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  ic3_pkg::ic3_sts_t sts,
  output ic3_pkg::ic3_cmd_t cmd
);
  import ic3_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_DINIT = 6'b000100,
    S_DIV   = 6'b001000,
    S_FIN   = 6'b010000,
    S_UPD   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [TAP_W-1:0] cnt_r, cnt_nxt;
  logic             wr_pend_r, wr_pend_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    wr_pend_nxt = wr_pend_r;
    cmd         = '0;
    cmd.tap     = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.start   = 1'b1;
          wr_pend_nxt = sts.need_write;
          cnt_nxt     = '0;
          if (sts.need_emit) state_nxt = S_FETCH;
          else if (sts.need_write) state_nxt = S_UPD;
        end
      end
      S_FETCH: begin
        // address phase of tap n overlaps the accumulate of tap n-1
        cmd.fetch = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == TAP_W'(TAPS)) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == TAP_W'(QBITS - 1)) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = wr_pend_r ? S_UPD : S_IDLE;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      wr_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      wr_pend_r <= wr_pend_nxt;
    end
  end

endmodule

// ===== design/ic3_dp.sv =====
module ic3_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ic3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ic3_pkg::CFG_DW-1:0]   cfg_wdata,
  input  logic [ic3_pkg::PIX_W-1:0]    in_tdata,
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ic3_pkg::PIX_W-1:0]    out_tdata,
  output logic                         out_tlast,
  input  ic3_pkg::ic3_cmd_t            cmd,
  output ic3_pkg::ic3_sts_t            sts
);
  import ic3_pkg::*;

  // configuration
  logic [WID_W-1:0]  eff_w_r;
  logic [HGT_W-1:0]  eff_h_r;
  logic [KROW_W-1:0] krow_r [3];
  logic [COL_W-1:0]  wm1;
  logic [ROW_W-1:0]  hm1;
  logic              restart_cfg;
  logic [WID_W-1:0]  w_val;
  logic [HGT_W-1:0]  h_val;

  // frame position
  logic [COL_W-1:0]  in_col_r, out_col_r;
  logic [ROW_W-1:0]  in_row_r, out_row_r;
  logic [SLOT_W-1:0] in_slot_r, out_slot_r;
  logic [WID_W-1:0]  pend_r;
  logic              done_r;
  logic              last_out;

  // item
  logic [PIX_W-1:0]  pix_r;
  logic              have_cur_r;

  // row ring
  logic [PIX_W-1:0]   ring [RING_DEPTH];
  logic [PIX_W-1:0]   rd_data_r;
  logic [RING_AW-1:0] raddr;
  logic               rd_en;

  // tap addressing
  logic [1:0]           t_r, t_c;
  logic [ROW_W-1:0]     tap_row;
  logic [SLOT_W-1:0]    tap_slot;
  logic [COL_W-1:0]     tap_col;
  logic [COEF_SLOT-1:0] coef_raw;
  logic                 sub_r, center_r;
  logic signed [COEF_BITS-1:0] coef_r;
  logic [PIX_W-1:0]     px;

  // accumulate and divide
  logic signed [ACC_W-1:0] acc_r [3];
  logic signed [KS_W-1:0]  ksum_r;
  logic [7:0]              alpha_r;
  logic [DIV_W-1:0]        rem_r [3];
  logic [DIV_W-1:0]        dsh_r;
  logic [QBITS-1:0]        q_r [3];
  logic [2:0]              zero_r, sat_r;
  logic signed [KS_W-1:0]  ks_eff;
  logic [DIV_W-1:0]        absk;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    slot_inc = (s == SLOT_W'(2)) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
    slot_dec = (s == '0) ? SLOT_W'(2) : s - 1'b1;
  endfunction

  assign wm1      = COL_W'(eff_w_r - 1'b1);
  assign hm1      = ROW_W'(eff_h_r - 1'b1);
  assign last_out = (out_row_r == hm1) && (out_col_r == wm1);

  assign sts.need_emit  = done_r || (!in_tuser && (pend_r > eff_w_r));
  assign sts.need_write = !done_r && !in_tuser;
  assign sts.out_busy   = out_tvalid;

  assign restart_cfg = cfg_we && ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT));

  always_comb begin
    w_val = cfg_wdata[WID_W-1:0];
    if (w_val == '0) w_val = WID_W'(1);
    else if (w_val > WID_W'(MAX_WIDTH)) w_val = WID_W'(MAX_WIDTH);
    h_val = cfg_wdata[HGT_W-1:0];
    if (h_val == '0) h_val = HGT_W'(1);
    else if (h_val > HGT_W'(MAX_HEIGHT)) h_val = HGT_W'(MAX_HEIGHT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r   <= WID_W'(1);
      eff_h_r   <= HGT_W'(1);
      krow_r[0] <= '0;
      krow_r[1] <= KROW_W'(1) << COEF_SLOT;
      krow_r[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH:  eff_w_r   <= w_val;
        CFG_HEIGHT: eff_h_r   <= h_val;
        CFG_KTOP:   krow_r[0] <= cfg_wdata[KROW_W-1:0];
        CFG_KMID:   krow_r[1] <= cfg_wdata[KROW_W-1:0];
        CFG_KBOT:   krow_r[2] <= cfg_wdata[KROW_W-1:0];
        default: ;
      endcase
    end
  end

  // tap geometry with edge replication
  always_comb begin
    case (cmd.tap)
      TAP_W'(0): begin t_r = 2'd0; t_c = 2'd0; end
      TAP_W'(1): begin t_r = 2'd0; t_c = 2'd1; end
      TAP_W'(2): begin t_r = 2'd0; t_c = 2'd2; end
      TAP_W'(3): begin t_r = 2'd1; t_c = 2'd0; end
      TAP_W'(4): begin t_r = 2'd1; t_c = 2'd1; end
      TAP_W'(5): begin t_r = 2'd1; t_c = 2'd2; end
      TAP_W'(6): begin t_r = 2'd2; t_c = 2'd0; end
      TAP_W'(7): begin t_r = 2'd2; t_c = 2'd1; end
      default:   begin t_r = 2'd2; t_c = 2'd2; end
    endcase
    case (t_r)
      2'd0: begin
        tap_row  = (out_row_r == '0) ? '0 : out_row_r - 1'b1;
        tap_slot = (out_row_r == '0) ? out_slot_r : slot_dec(out_slot_r);
      end
      2'd2: begin
        tap_row  = (out_row_r == hm1) ? out_row_r : out_row_r + 1'b1;
        tap_slot = (out_row_r == hm1) ? out_slot_r : slot_inc(out_slot_r);
      end
      default: begin
        tap_row  = out_row_r;
        tap_slot = out_slot_r;
      end
    endcase
    case (t_c)
      2'd0:    tap_col = (out_col_r == '0) ? '0 : out_col_r - 1'b1;
      2'd2:    tap_col = (out_col_r == wm1) ? out_col_r : out_col_r + 1'b1;
      default: tap_col = out_col_r;
    endcase
    case (t_c)
      2'd0:    coef_raw = krow_r[t_r][COEF_SLOT-1:0];
      2'd1:    coef_raw = krow_r[t_r][2*COEF_SLOT-1:COEF_SLOT];
      default: coef_raw = krow_r[t_r][3*COEF_SLOT-1:2*COEF_SLOT];
    endcase
  end

  assign rd_en = cmd.fetch && (cmd.tap < TAP_W'(TAPS));
  assign raddr = {tap_slot, tap_col};

  always_ff @(posedge clk) begin
    if (cmd.update) ring[{in_slot_r, in_col_r}] <= pix_r;
    if (rd_en) rd_data_r <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      // the pixel of this item is not yet in the ring
      sub_r    <= have_cur_r && (tap_row == in_row_r) && (tap_col == in_col_r);
      coef_r   <= $signed(coef_raw[COEF_BITS-1:0]);
      center_r <= (t_r == 2'd1) && (t_c == 2'd1);
    end
  end

  assign px = sub_r ? pix_r : rd_data_r;

  assign ks_eff = (ksum_r == '0) ? KS_W'(1) : ksum_r;
  assign absk   = ks_eff[KS_W-1] ? DIV_W'(-ks_eff) : DIV_W'(ks_eff);

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pix_r      <= in_tdata;
      have_cur_r <= !done_r;
      ksum_r     <= '0;
      for (int ch = 0; ch < 3; ch++) acc_r[ch] <= '0;
    end else if (cmd.fetch && (cmd.tap != '0)) begin
      ksum_r <= ksum_r + KS_W'(coef_r);
      for (int ch = 0; ch < 3; ch++)
        acc_r[ch] <= acc_r[ch] + ACC_W'($signed({1'b0, px[8*ch +: 8]}) * coef_r);
      if (center_r) alpha_r <= px[31:24];
    end
    if (cmd.div_init) begin
      dsh_r <= absk << (QBITS - 1);
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch]  <= acc_r[ch][ACC_W-1] ? DIV_W'(-acc_r[ch]) : DIV_W'(acc_r[ch]);
        zero_r[ch] <= acc_r[ch][ACC_W-1] ^ ks_eff[KS_W-1];
        sat_r[ch]  <= (acc_r[ch][ACC_W-1] ? DIV_W'(-acc_r[ch]) : DIV_W'(acc_r[ch]))
                      >= (absk << QBITS);
        q_r[ch]    <= '0;
      end
    end else if (cmd.div_step) begin
      dsh_r <= dsh_r >> 1;
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= dsh_r) begin
          rem_r[ch] <= rem_r[ch] - dsh_r;
          q_r[ch]   <= {q_r[ch][QBITS-2:0], 1'b1};
        end else begin
          q_r[ch]   <= {q_r[ch][QBITS-2:0], 1'b0};
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      out_tvalid <= 1'b1;
    end else if (out_tready) begin
      out_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int ch = 0; ch < 3; ch++)
        out_tdata[8*ch +: 8] <= zero_r[ch] ? 8'd0 : sat_r[ch] ? 8'(CHAN_MAX) : q_r[ch];
      out_tdata[31:24] <= alpha_r;
      out_tlast        <= last_out;
    end
  end

  // frame position
  always_ff @(posedge clk) begin
    if (!rst_n || restart_cfg || (cmd.finish && last_out)) begin
      in_col_r   <= '0;
      in_row_r   <= '0;
      in_slot_r  <= '0;
      out_col_r  <= '0;
      out_row_r  <= '0;
      out_slot_r <= '0;
      pend_r     <= '0;
      done_r     <= 1'b0;
    end else if (cmd.finish) begin
      pend_r <= pend_r - 1'b1;
      if (out_col_r == wm1) begin
        out_col_r  <= '0;
        out_row_r  <= out_row_r + 1'b1;
        out_slot_r <= slot_inc(out_slot_r);
      end else begin
        out_col_r <= out_col_r + 1'b1;
      end
    end else if (cmd.update) begin
      pend_r <= pend_r + 1'b1;
      if (in_col_r == wm1) begin
        in_col_r <= '0;
        if (in_row_r == hm1) begin
          done_r <= 1'b1;
        end else begin
          in_row_r  <= in_row_r + 1'b1;
          in_slot_r <= slot_inc(in_slot_r);
        end
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end
  end

endmodule

// ===== design/image_convolution_3x3_top.sv =====
// Channel  Dir  Payload
// in_      in   tdata: red, green, blue, alpha; tuser: drain flag
// out_     out  tdata: red, green, blue, alpha; tlast: last pixel of frame
// cfg_     in   write enable, register index, 48-bit data
//
// A pixel that only fills the row ring is taken and then written; an item that yields a
// result is taken, runs the nine taps through the single ring read port, then the
// divide set-up and the one-bit-per-cycle divide, and loads the result;
// a pixel that also yields a result then does its ring write.
// A drain item with nothing pending is only taken.
// rst_n is synchronous; the ring needs no clearing, rows are written first.
// A result waits in the output register; the next item is taken meanwhile
// and stalls only at its own result while that register is full.
module image_convolution_3x3_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [ic3_pkg::PIX_W-1:0]     in_tdata,   // red, green, blue, alpha
  input  logic                          in_tuser,   // drain item
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [ic3_pkg::PIX_W-1:0]     out_tdata,  // red, green, blue, alpha
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [ic3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ic3_pkg::CFG_DW-1:0]    cfg_wdata
);
  import ic3_pkg::*;

  ic3_cmd_t cmd;
  ic3_sts_t sts;

  ic3_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ic3_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ===== design/ic3_checker.sv =====
module ic3_sva (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_tready,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [ic3_pkg::PIX_W-1:0]     out_tdata,
  input logic                          out_tlast
);
`include "image_convolution_3x3_top_macros.svh"

  `IC3_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")
  `IC3_ASSERT_ALWAYS(a_reset_ready, !rst_n |=> in_tready, "input not ready after reset")
  `IC3_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `IC3_ASSERT_RUN(a_out_gap, out_tvalid && out_tready |=> !out_tvalid, "result reloaded on transfer")

endmodule

bind image_convolution_3x3_top ic3_sva u_ic3_sva (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
